@@ rtl/assert_macros.svh @@
// Assertion helpers used by one_wire_temperature_master.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define OWTM_ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define OWTM_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

@@ rtl/owtm_pkg.sv @@
// ----------------------------------------------------------------------------
// owtm_pkg
// Types, constants and the command sequence table of the 1-Wire master.
// ----------------------------------------------------------------------------
`default_nettype none

package owtm_pkg;

   localparam int DurW = 10;

   typedef enum logic [9:0] {
      PH_IDLE     = 10'b0000000001,
      PH_RST_LOW  = 10'b0000000010,
      PH_RST_WAIT = 10'b0000000100,
      PH_RST_REC  = 10'b0000001000,
      PH_W_START  = 10'b0000010000,
      PH_W_HOLD   = 10'b0000100000,
      PH_W_REC    = 10'b0001000000,
      PH_R_START  = 10'b0010000000,
      PH_R_WAIT   = 10'b0100000000,
      PH_R_REC    = 10'b1000000000
   } phase_type;

   typedef enum logic [2:0] {
      EL_DONE  = 3'd0,
      EL_RESET = 3'd1,
      EL_WR_IN = 3'd2,
      EL_WR_CC = 3'd3,
      EL_WR_44 = 3'd4,
      EL_WR_BE = 3'd5,
      EL_READ  = 3'd6
   } element_type;

   typedef enum logic [2:0] {
      OP_RESET      = 3'd0,
      OP_WRITE_BYTE = 3'd1,
      OP_READ_BYTE  = 3'd2,
      OP_CONVERT    = 3'd3,
      OP_READ_TEMP  = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      REG_RESET_LOW      = 3'd0,
      REG_PRESENCE_WAIT  = 3'd1,
      REG_RESET_RECOVERY = 3'd2,
      REG_SLOT_START     = 3'd3,
      REG_WRITE_HOLD     = 3'd4,
      REG_READ_SAMPLE    = 3'd5,
      REG_READ_RECOVERY  = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [9:0] reset_low_us;
      logic [7:0] presence_wait_us;
      logic [9:0] reset_recovery_us;
      logic [3:0] slot_start_us;
      logic [6:0] write_hold_us;
      logic [5:0] read_sample_us;
      logic [6:0] read_recovery_us;
   } cfg_type;

   localparam logic [7:0] CmdSkipRom   = 8'hCC;
   localparam logic [7:0] CmdConvert   = 8'h44;
   localparam logic [7:0] CmdReadPad   = 8'hBE;
   localparam logic [2:0] LastBit      = 3'd7;
   localparam logic [2:0] StepLowByte  = 3'd3;
   localparam logic [2:0] StepHighByte = 3'd4;

   function automatic element_type seq_elem(input logic [2:0] op, input logic [2:0] step);
      element_type el;
      el = EL_DONE;
      case (op)
         OP_RESET:      el = (step == 3'd0) ? EL_RESET : EL_DONE;
         OP_WRITE_BYTE: el = (step == 3'd0) ? EL_WR_IN : EL_DONE;
         OP_READ_BYTE:  el = (step == 3'd0) ? EL_READ : EL_DONE;
         OP_CONVERT: begin
            case (step)
               3'd0:    el = EL_RESET;
               3'd1:    el = EL_WR_CC;
               3'd2:    el = EL_WR_44;
               default: el = EL_DONE;
            endcase
         end
         OP_READ_TEMP: begin
            case (step)
               3'd0:    el = EL_RESET;
               3'd1:    el = EL_WR_CC;
               3'd2:    el = EL_WR_BE;
               3'd3:    el = EL_READ;
               3'd4:    el = EL_READ;
               default: el = EL_DONE;
            endcase
         end
         default: el = EL_DONE;
      endcase
      return el;
   endfunction

endpackage

`default_nettype wire

@@ rtl/owtm_csr.sv @@
// ----------------------------------------------------------------------------
// owtm_csr
// Timing register file of the 1-Wire master, written one beat at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module owtm_csr (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [2:0]        csr_index,
   input  wire logic [9:0]        csr_data,
   output owtm_pkg::cfg_type      cfg
);

   owtm_pkg::cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_us      <= 10'd500;
         cfg_ff.presence_wait_us  <= 8'd70;
         cfg_ff.reset_recovery_us <= 10'd500;
         cfg_ff.slot_start_us     <= 4'd2;
         cfg_ff.write_hold_us     <= 7'd60;
         cfg_ff.read_sample_us    <= 6'd12;
         cfg_ff.read_recovery_us  <= 7'd50;
      end else if (csr_valid) begin
         case (csr_index)
            owtm_pkg::REG_RESET_LOW:      cfg_ff.reset_low_us      <= csr_data;
            owtm_pkg::REG_PRESENCE_WAIT:  cfg_ff.presence_wait_us  <= csr_data[7:0];
            owtm_pkg::REG_RESET_RECOVERY: cfg_ff.reset_recovery_us <= csr_data;
            owtm_pkg::REG_SLOT_START:     cfg_ff.slot_start_us     <= csr_data[3:0];
            owtm_pkg::REG_WRITE_HOLD:     cfg_ff.write_hold_us     <= csr_data[6:0];
            owtm_pkg::REG_READ_SAMPLE:    cfg_ff.read_sample_us    <= csr_data[5:0];
            owtm_pkg::REG_READ_RECOVERY:  cfg_ff.read_recovery_us  <= csr_data[6:0];
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

@@ rtl/one_wire_temperature_master.sv @@
// Result: an accepted input beat gives its result beat in the next cycle.
// Throughput: one input beat per cycle while result beats are taken; the
// result register frees itself in the same cycle that its beat is taken.
// Reset: synchronous, active high; timing registers return to their
// defaults and the bus sequencer returns to idle with all status cleared.
// ----------------------------------------------------------------------------
// one_wire_temperature_master
// 1-Wire bus master with reset, byte write, byte read, conversion start and
// temperature read sequences, timed by a microsecond strobe in each beat.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module one_wire_temperature_master #(
   parameter int TIMER_BITS = 10
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_tick,
   input  wire logic        req_bus_level,
   input  wire logic        req_start_req,
   input  wire logic [2:0]  req_type,
   input  wire logic [7:0]  req_write_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_bus_pull_low,
   output logic             rsp_busy_res,
   output logic             rsp_done_res,
   output logic             rsp_present,
   output logic [7:0]       rsp_read_data,
   output logic signed [15:0] rsp_temperature,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [9:0]  csr_data
);

   localparam int CmpW = (TIMER_BITS > owtm_pkg::DurW) ? TIMER_BITS : owtm_pkg::DurW;

   owtm_pkg::cfg_type cfg;

   owtm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   owtm_pkg::phase_type   phase_ff, phase_in;
   logic [TIMER_BITS-1:0] timer_ff, timer_in;
   logic [2:0]            bit_ff, bit_in;
   logic [7:0]            shift_ff, shift_in;
   logic [2:0]            step_ff, step_in;
   logic [2:0]            op_ff, op_in;
   logic [7:0]            low_ff, low_in;
   logic                  presence_ff, presence_in;
   logic [7:0]            read_ff, read_in;
   logic [15:0]           temp_ff, temp_in;
   logic                  done_ff, done_in;
   logic                  rsp_valid_ff;

   logic                  in_accept;
   logic [owtm_pkg::DurW-1:0] dur;
   logic                  expired;
   logic                  start_el;
   logic [2:0]            el_op;
   logic [2:0]            el_step;
   logic [7:0]            el_wbyte;
   owtm_pkg::element_type el;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign in_accept = req_valid && req_ready;

   always_comb begin
      case (phase_ff)
         owtm_pkg::PH_RST_LOW:  dur = cfg.reset_low_us;
         owtm_pkg::PH_RST_WAIT: dur = {2'b00, cfg.presence_wait_us};
         owtm_pkg::PH_RST_REC:  dur = cfg.reset_recovery_us;
         owtm_pkg::PH_W_START:  dur = {6'd0, cfg.slot_start_us};
         owtm_pkg::PH_W_HOLD:   dur = {3'd0, cfg.write_hold_us};
         owtm_pkg::PH_W_REC:    dur = {6'd0, cfg.slot_start_us};
         owtm_pkg::PH_R_START:  dur = {6'd0, cfg.slot_start_us};
         owtm_pkg::PH_R_WAIT:   dur = {4'd0, cfg.read_sample_us};
         owtm_pkg::PH_R_REC:    dur = {3'd0, cfg.read_recovery_us};
         default:               dur = '0;
      endcase
   end

   assign expired = (CmpW'(timer_ff) >= CmpW'(dur)) || (&timer_ff);

   always_comb begin
      phase_in    = phase_ff;
      timer_in    = timer_ff;
      bit_in      = bit_ff;
      shift_in    = shift_ff;
      step_in     = step_ff;
      op_in       = op_ff;
      low_in      = low_ff;
      presence_in = presence_ff;
      read_in     = read_ff;
      temp_in     = temp_ff;
      done_in     = 1'b0;
      start_el    = 1'b0;
      el_op       = op_ff;
      el_step     = step_ff + 3'd1;
      el_wbyte    = 8'h00;

      if (phase_ff == owtm_pkg::PH_IDLE) begin
         if (req_start_req && (req_type <= owtm_pkg::OP_READ_TEMP)) begin
            op_in    = req_type;
            step_in  = 3'd0;
            el_op    = req_type;
            el_step  = 3'd0;
            el_wbyte = req_write_byte;
            start_el = 1'b1;
         end
      end else if (expired) begin
         timer_in = '0;
         case (phase_ff)
            owtm_pkg::PH_RST_LOW:  phase_in = owtm_pkg::PH_RST_WAIT;
            owtm_pkg::PH_RST_WAIT: begin
               presence_in = !req_bus_level;
               phase_in    = owtm_pkg::PH_RST_REC;
            end
            owtm_pkg::PH_RST_REC: begin
               step_in  = el_step;
               start_el = 1'b1;
            end
            owtm_pkg::PH_W_START:  phase_in = owtm_pkg::PH_W_HOLD;
            owtm_pkg::PH_W_HOLD:   phase_in = owtm_pkg::PH_W_REC;
            owtm_pkg::PH_W_REC: begin
               shift_in = {1'b0, shift_ff[7:1]};
               if (bit_ff == owtm_pkg::LastBit) begin
                  step_in  = el_step;
                  start_el = 1'b1;
               end else begin
                  bit_in   = bit_ff + 3'd1;
                  phase_in = owtm_pkg::PH_W_START;
               end
            end
            owtm_pkg::PH_R_START:  phase_in = owtm_pkg::PH_R_WAIT;
            owtm_pkg::PH_R_WAIT: begin
               shift_in = {req_bus_level, shift_ff[7:1]};
               phase_in = owtm_pkg::PH_R_REC;
            end
            owtm_pkg::PH_R_REC: begin
               if (bit_ff == owtm_pkg::LastBit) begin
                  read_in = shift_ff;
                  if (op_ff == owtm_pkg::OP_READ_TEMP && step_ff == owtm_pkg::StepLowByte) begin
                     low_in = shift_ff;
                  end
                  if (op_ff == owtm_pkg::OP_READ_TEMP && step_ff == owtm_pkg::StepHighByte) begin
                     temp_in = {shift_ff, low_ff};
                  end
                  step_in  = el_step;
                  start_el = 1'b1;
               end else begin
                  bit_in   = bit_ff + 3'd1;
                  phase_in = owtm_pkg::PH_R_START;
               end
            end
            default: phase_in = owtm_pkg::PH_IDLE;
         endcase
      end else if (req_tick) begin
         timer_in = timer_ff + 1'b1;
      end

      el = owtm_pkg::seq_elem(el_op, el_step);
      if (start_el) begin
         bit_in   = 3'd0;
         timer_in = '0;
         case (el)
            owtm_pkg::EL_RESET: phase_in = owtm_pkg::PH_RST_LOW;
            owtm_pkg::EL_WR_IN: begin
               shift_in = el_wbyte;
               phase_in = owtm_pkg::PH_W_START;
            end
            owtm_pkg::EL_WR_CC: begin
               shift_in = owtm_pkg::CmdSkipRom;
               phase_in = owtm_pkg::PH_W_START;
            end
            owtm_pkg::EL_WR_44: begin
               shift_in = owtm_pkg::CmdConvert;
               phase_in = owtm_pkg::PH_W_START;
            end
            owtm_pkg::EL_WR_BE: begin
               shift_in = owtm_pkg::CmdReadPad;
               phase_in = owtm_pkg::PH_W_START;
            end
            owtm_pkg::EL_READ: begin
               shift_in = 8'h00;
               phase_in = owtm_pkg::PH_R_START;
            end
            default: begin
               phase_in = owtm_pkg::PH_IDLE;
               done_in  = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= owtm_pkg::PH_IDLE;
         timer_ff     <= '0;
         bit_ff       <= '0;
         shift_ff     <= '0;
         step_ff      <= '0;
         op_ff        <= '0;
         low_ff       <= '0;
         presence_ff  <= 1'b0;
         read_ff      <= '0;
         temp_ff      <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (in_accept) begin
            phase_ff    <= phase_in;
            timer_ff    <= timer_in;
            bit_ff      <= bit_in;
            shift_ff    <= shift_in;
            step_ff     <= step_in;
            op_ff       <= op_in;
            low_ff      <= low_in;
            presence_ff <= presence_in;
            read_ff     <= read_in;
            temp_ff     <= temp_in;
            done_ff     <= done_in;
         end
         if (in_accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      case (phase_ff)
         owtm_pkg::PH_RST_LOW: rsp_bus_pull_low = 1'b1;
         owtm_pkg::PH_W_START: rsp_bus_pull_low = 1'b1;
         owtm_pkg::PH_R_START: rsp_bus_pull_low = 1'b1;
         owtm_pkg::PH_W_HOLD:  rsp_bus_pull_low = !shift_ff[0];
         default:              rsp_bus_pull_low = 1'b0;
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_busy_res    = (phase_ff != owtm_pkg::PH_IDLE);
   assign rsp_done_res    = done_ff;
   assign rsp_present     = presence_ff;
   assign rsp_read_data   = read_ff;
   assign rsp_temperature = $signed(temp_ff);

   `OWTM_ASSERT_IMPL(a_done_idle, clock, reset, done_ff, phase_ff == owtm_pkg::PH_IDLE,
      "done reported while the sequencer is still busy")
   `OWTM_ASSERT_IMPL(a_pull_busy, clock, reset, rsp_bus_pull_low, rsp_busy_res,
      "bus driven low while idle")
   `OWTM_ASSERT_NEXT(a_hold_state, clock, reset, !in_accept,
      $stable(phase_ff) && $stable(timer_ff) && $stable(done_ff),
      "sequencer state moved without an input beat")

endmodule

`default_nettype wire
